@@ src/rqpd_pkg.sv @@
// Shared types and constants for the receive queue packet deframer.
package rqpd_pkg;

  // Fixed field widths
  localparam int TERM_W   = 5;   // terminator count, wraps at 32
  localparam int CNT_W    = 8;   // drop and bad frame counters
  localparam int IDX_W    = 3;   // byte index and packet length
  localparam int STAT_W   = 3;
  localparam int MAX_DATA = 7;   // data bytes kept for one packet

  // Operation codes
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED   = 3'd2;
  localparam logic [STAT_W-1:0] ST_CKSUM     = 3'd3;
  localparam logic [STAT_W-1:0] ST_MALFORMED = 3'd4;

  // Controller states
  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_PUSH     = 9'b000000010,
    S_POP      = 9'b000000100,
    S_POP_DATA = 9'b000001000,
    S_RD_START = 9'b000010000,
    S_SCAN     = 9'b000100000,
    S_REPLY    = 9'b001000000,
    S_EMIT     = 9'b010000000,
    S_SPARE    = 9'b100000000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic push;
    logic pop_start;
    logic pop_capture;
    logic read_start;
    logic scan;
    logic reply;
    logic emit;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic ring_empty;
    logic tc_zero;
    logic scan_end;
    logic scan_good;
    logic emit_last;
    logic out_free;
  } dp_stat_t;

endpackage

@@ src/rqpd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rqpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/rqpd_ctrl.sv @@
// Controller state machine: sequences push, pop and packet read operations.
module rqpd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         op,
  output logic               in_ready,
  input  rqpd_pkg::dp_stat_t stat,
  output rqpd_pkg::dp_cmd_t  cmd
);

  rqpd_pkg::state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rqpd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == rqpd_pkg::S_IDLE);

  // Decode commands and advance
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      rqpd_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (op)
            rqpd_pkg::OP_PUSH: state_next = rqpd_pkg::S_PUSH;
            rqpd_pkg::OP_POP:  state_next = rqpd_pkg::S_POP;
            rqpd_pkg::OP_READ: state_next = rqpd_pkg::S_RD_START;
            default:           state_next = rqpd_pkg::S_IDLE;
          endcase
        end
      end
      rqpd_pkg::S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = rqpd_pkg::S_REPLY;
      end
      rqpd_pkg::S_POP: begin
        cmd.pop_start = 1'b1;
        state_next    = stat.ring_empty ? rqpd_pkg::S_REPLY : rqpd_pkg::S_POP_DATA;
      end
      rqpd_pkg::S_POP_DATA: begin
        cmd.pop_capture = 1'b1;
        state_next      = rqpd_pkg::S_REPLY;
      end
      rqpd_pkg::S_RD_START: begin
        cmd.read_start = 1'b1;
        state_next     = stat.tc_zero ? rqpd_pkg::S_REPLY : rqpd_pkg::S_SCAN;
      end
      rqpd_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) begin
          state_next = stat.scan_good ? rqpd_pkg::S_EMIT : rqpd_pkg::S_REPLY;
        end
      end
      rqpd_pkg::S_REPLY: begin
        if (stat.out_free) begin
          cmd.reply  = 1'b1;
          state_next = rqpd_pkg::S_IDLE;
        end
      end
      rqpd_pkg::S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_next = rqpd_pkg::S_IDLE;
          end
        end
      end
      default: state_next = rqpd_pkg::S_IDLE;
    endcase
  end

endmodule

@@ src/rqpd_dp.sv @@
// Datapath: ring pointers, counters, frame scan registers and output register.
module rqpd_dp #(
  parameter int QUEUE_DEPTH    = 32,
  parameter int MAX_FRAME_SCAN = 9
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rqpd_pkg::dp_cmd_t                   cmd,
  output rqpd_pkg::dp_stat_t                  stat,
  input  logic [7:0]                          rx_byte,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [7:0]                          data_byte,
  output logic [rqpd_pkg::IDX_W-1:0]          byte_index,
  output logic                                last,
  output logic [rqpd_pkg::STAT_W-1:0]         status,
  output logic [rqpd_pkg::IDX_W-1:0]          packet_length,
  output logic [rqpd_pkg::CNT_W-1:0]          overflow_count,
  output logic [rqpd_pkg::CNT_W-1:0]          checksum_error_count,
  output logic [rqpd_pkg::TERM_W-1:0]         pending_packets
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int SW = $clog2(MAX_FRAME_SCAN + 1);

  // Control registers
  logic [PW-1:0]               rp, wp;
  logic [rqpd_pkg::TERM_W-1:0] tc;
  logic [rqpd_pkg::CNT_W-1:0]  drop_cnt, bad_cnt;

  // Payload registers
  logic [7:0]                  byte_hold;
  logic [7:0]                  reply_data;
  logic [rqpd_pkg::STAT_W-1:0] reply_status;
  logic [SW-1:0]               scan_cnt;
  logic [6:0]                  acc;
  logic [7:0]                  eighth;
  logic [6:0]                  data_buf [rqpd_pkg::MAX_DATA];
  logic [rqpd_pkg::IDX_W-1:0]  frame_len;
  logic [rqpd_pkg::IDX_W-1:0]  emit_idx;

  logic [PW-1:0]               wp_inc, rp_inc;
  logic                        ring_full, ring_empty, tc_zero;
  logic [7:0]                  ram_q;
  logic                        is_data, last_slot, short_frame, crc_ok;
  logic [rqpd_pkg::IDX_W-1:0]  frame_len_c;
  logic [6:0]                  crc;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Ring bookkeeping
  assign wp_inc     = ptr_inc(wp);
  assign rp_inc     = ptr_inc(rp);
  assign ring_full  = (wp_inc == rp);
  assign ring_empty = (rp == wp);
  assign tc_zero    = (tc == '0);

  rqpd_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.push && !ring_full),
    .waddr (wp),
    .wdata (byte_hold),
    .raddr (rp),
    .rdata (ram_q)
  );

  // Classify the scanned byte; bit 7 of restored bytes drops out of the 7-bit sum
  assign is_data     = ram_q[7];
  assign last_slot   = (scan_cnt == SW'(MAX_FRAME_SCAN - 1));
  assign short_frame = (scan_cnt < SW'(2));
  assign frame_len_c = rqpd_pkg::IDX_W'(scan_cnt - 1'b1);
  assign crc         = acc + 7'(frame_len_c);
  assign crc_ok      = (crc == ram_q[6:0]);

  assign stat.ring_empty = ring_empty;
  assign stat.tc_zero    = tc_zero;
  assign stat.scan_end   = !is_data || last_slot;
  assign stat.scan_good  = !is_data && !short_frame && crc_ok;
  assign stat.emit_last  = (emit_idx == frame_len - 3'd1);
  assign stat.out_free   = !out_valid || out_ready;

  // Update pointers, counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rp        <= '0;
      wp        <= '0;
      tc        <= '0;
      drop_cnt  <= '0;
      bad_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.push) begin
        if (ring_full) begin
          drop_cnt <= drop_cnt + 1'b1;
          if (tc_zero) begin
            rp <= '0;
            wp <= '0;
          end
        end else begin
          wp <= wp_inc;
          if (!byte_hold[7]) begin
            tc <= tc + 1'b1;
          end
        end
      end
      if (cmd.pop_start && !ring_empty) begin
        rp <= rp_inc;
      end
      if (cmd.read_start && !tc_zero) begin
        rp <= rp_inc;
      end
      if (cmd.scan) begin
        if (is_data) begin
          if (last_slot) begin
            bad_cnt <= bad_cnt + 1'b1;
          end else begin
            rp <= rp_inc;
          end
        end else begin
          tc <= tc - 1'b1;
          if (short_frame || !crc_ok) begin
            bad_cnt <= bad_cnt + 1'b1;
          end
        end
      end
      if (cmd.reply || cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture operands, scan bytes and load the output word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_hold <= rx_byte;
    end
    if (cmd.push) begin
      reply_data   <= '0;
      reply_status <= ring_full ? rqpd_pkg::ST_DROPPED : rqpd_pkg::ST_OK;
    end
    if (cmd.pop_start) begin
      reply_data   <= '0;
      reply_status <= ring_empty ? rqpd_pkg::ST_EMPTY : rqpd_pkg::ST_OK;
    end
    if (cmd.pop_capture) begin
      reply_data <= ram_q;
    end
    if (cmd.read_start) begin
      reply_data   <= '0;
      reply_status <= rqpd_pkg::ST_EMPTY;
      scan_cnt     <= '0;
      acc          <= '0;
    end
    if (cmd.scan) begin
      if (is_data) begin
        if (int'(scan_cnt) < rqpd_pkg::MAX_DATA) begin
          data_buf[rqpd_pkg::IDX_W'(scan_cnt)] <= ram_q[6:0];
        end
        eighth   <= ram_q;
        acc      <= acc + ram_q[6:0];
        scan_cnt <= scan_cnt + 1'b1;
        if (last_slot) begin
          reply_status <= rqpd_pkg::ST_MALFORMED;
        end
      end else begin
        frame_len <= frame_len_c;
        emit_idx  <= '0;
        if (short_frame) begin
          reply_status <= rqpd_pkg::ST_MALFORMED;
        end else if (!crc_ok) begin
          reply_status <= rqpd_pkg::ST_CKSUM;
        end else begin
          reply_status <= rqpd_pkg::ST_OK;
        end
      end
    end
    if (cmd.reply) begin
      data_byte            <= reply_data;
      byte_index           <= '0;
      last                 <= 1'b1;
      status               <= reply_status;
      packet_length        <= '0;
      overflow_count       <= drop_cnt;
      checksum_error_count <= bad_cnt;
      pending_packets      <= tc;
    end
    if (cmd.emit) begin
      // Restore bit 7 from the eighth-bits byte
      data_byte            <= {eighth[emit_idx], data_buf[emit_idx]};
      byte_index           <= emit_idx;
      last                 <= stat.emit_last;
      status               <= rqpd_pkg::ST_OK;
      packet_length        <= frame_len;
      overflow_count       <= drop_cnt;
      checksum_error_count <= bad_cnt;
      pending_packets      <= tc;
      emit_idx             <= emit_idx + 1'b1;
    end
  end

endmodule

@@ src/rx_queue_packet_deframer_top.sv @@
// Top level of the receive queue packet deframer: controller, datapath, checks.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   in      | input     | in_valid / in_ready  | op, rx_byte
//   out     | output    | out_valid / out_ready| data_byte, byte_index, last, status,
//           |           |                      | packet_length, overflow_count,
//           |           |                      | checksum_error_count, pending_packets
//
// One word is taken at a time. A packet read scans s ring entries one per cycle through
// the ring RAM's registered read port (s up to MAX_FRAME_SCAN), then sends n result words
// (n = 1 for a status word, else the packet length), one per cycle while the output is
// free.
// Reset clears pointers, counters and the controller; ring contents are not cleared.
// A stalled result waits in the output register; a new word is accepted meanwhile.
module rx_queue_packet_deframer_top #(
  parameter int QUEUE_DEPTH    = 32,
  parameter int MAX_FRAME_SCAN = 9
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic [2:0] byte_index,
  output logic       last,
  output logic [2:0] status,
  output logic [2:0] packet_length,
  output logic [7:0] overflow_count,
  output logic [7:0] checksum_error_count,
  output logic [4:0] pending_packets
);

  rqpd_pkg::dp_cmd_t  cmd;
  rqpd_pkg::dp_stat_t stat;

  rqpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rqpd_dp #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .MAX_FRAME_SCAN (MAX_FRAME_SCAN)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .stat                 (stat),
    .rx_byte              (rx_byte),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .data_byte            (data_byte),
    .byte_index           (byte_index),
    .last                 (last),
    .status               (status),
    .packet_length        (packet_length),
    .overflow_count       (overflow_count),
    .checksum_error_count (checksum_error_count),
    .pending_packets      (pending_packets)
  );

  // An ignored operation code leaves the block ready
  a_unknown_op_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (op != rqpd_pkg::OP_PUSH) && (op != rqpd_pkg::OP_POP) &&
    (op != rqpd_pkg::OP_READ) |=> in_ready)
    else $error("ignored operation left the block busy");

  // Every word with an error status is a single, final word
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != rqpd_pkg::ST_OK) |->
    last && (byte_index == 3'd0) && (packet_length == 3'd0))
    else $error("status word not marked last or carries packet fields");

  // Packet data words stay within the decoded length
  a_index_in_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (packet_length != 3'd0) |->
    (byte_index < packet_length) && (status == rqpd_pkg::ST_OK) &&
    (last == (byte_index == packet_length - 3'd1)))
    else $error("packet data word index or last mark out of place");

endmodule
